// ===== hw/rtl/dtx_pkg.sv =====
// ----------------------------------------------------------------------------
// City-block distance transform package
// Shared types, sizes and helper functions of the distance transform core.
// ----------------------------------------------------------------------------
package dtx_pkg;

   localparam int MAX_ROWS  = 128;
   localparam int MAX_COLS  = 128;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int DIST_W    = 8;
   localparam int ENTRY_W   = DIST_W + 1;
   localparam int REG_W     = 8;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;

   localparam logic [DIST_W-1:0] DIST_INF = '1;

   typedef struct packed {
      logic             mode;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             pixel;
   } dtx_req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              no_white;
      logic              outside;
   } dtx_rsp_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [ENTRY_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } mem_rd_type;

   typedef struct packed {
      logic busy;
      logic any_white;
   } scan_stat_type;

   typedef enum logic {
      REG_NUM_ROWS = 1'b0,
      REG_NUM_COLS = 1'b1
   } reg_idx_type;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   function automatic logic [DIST_W-1:0] dist_inc(input logic [DIST_W-1:0] v);
      logic [DIST_W-1:0] r;
      if (v >= DIST_INF - DIST_W'(1)) begin
         r = DIST_INF;
      end else begin
         r = v + DIST_W'(1);
      end
      return r;
   endfunction

   function automatic logic [DIST_W-1:0] dist_min(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ===== hw/rtl/binary_image_distance_transform_core.sv =====
// ----------------------------------------------------------------------------
// City-block distance transform core
// A pixel write goes to the store on its beat and the core stays ready;
// a read passes ST_LOOK and ST_EMIT, an outside access only ST_EMIT, and
// ST_EMIT holds the result while the output is stalled. A read after a write
// or a register change first runs the two raster passes of the scan engine,
// at one pixel a cycle. Reset: synchronous; then a clearing pass writes all
// 16384 store entries, one a cycle, and no input beat is taken until it ends.
// ----------------------------------------------------------------------------
module binary_image_distance_transform_core
   import dtx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dtx_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dtx_rsp_type        rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LOOK,
      ST_EMIT
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff;
   logic [ADDR_W-1:0]  clr_cnt_in;
   dtx_req_type        item_ff;
   dtx_req_type        item_in;
   logic               stale_ff;
   logic               stale_in;
   dtx_rsp_type        res_ff;
   dtx_rsp_type        res_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   dtx_rsp_type        rsp_data_ff;
   dtx_rsp_type        rsp_data_in;

   logic [REG_W-1:0]   eff_rows;
   logic [REG_W-1:0]   eff_cols;
   logic               cfg_write;
   logic               accept;
   logic               req_outside;
   logic               scan_start;
   mem_rd_type         scan_rd;
   mem_wr_type         scan_wr;
   scan_stat_type      scan_stat;
   mem_rd_type         mem_rd;
   mem_wr_type         mem_wr;
   logic [ENTRY_W-1:0] rd_data_a;
   logic [ENTRY_W-1:0] rd_data_b;

   dtx_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .eff_rows (eff_rows),
      .eff_cols (eff_cols),
      .cfg_write(cfg_write)
   );

   dtx_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .eff_rows (eff_rows),
      .eff_cols (eff_cols),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b),
      .scan_rd  (scan_rd),
      .scan_wr  (scan_wr),
      .stat     (scan_stat)
   );

   dtx_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (mem_wr),
      .rd       (mem_rd),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign req_outside = ({1'b0, req_data.row} >= eff_rows) ||
                        ({1'b0, req_data.col} >= eff_cols);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      item_in      = item_ff;
      stale_in     = stale_ff || cfg_write;
      res_in       = res_ff;
      scan_start   = 1'b0;
      mem_wr       = scan_wr;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (scan_stat.busy) begin
         mem_rd = scan_rd;
      end else if (state_ff == ST_IDLE) begin
         mem_rd.addr_a = {req_data.row, req_data.col};
         mem_rd.addr_b = {req_data.row, req_data.col};
      end else begin
         mem_rd.addr_a = {item_ff.row, item_ff.col};
         mem_rd.addr_b = {item_ff.row, item_ff.col};
      end
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = clr_cnt_ff;
            mem_wr.data = {1'b0, DIST_INF};
            clr_cnt_in  = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_outside) begin
                  res_in.distance = '0;
                  res_in.no_white = 1'b0;
                  res_in.outside  = 1'b1;
                  state_in        = ST_EMIT;
               end else if (req_data.mode == MODE_WRITE) begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = {req_data.row, req_data.col};
                  mem_wr.data = {req_data.pixel, DIST_INF};
                  stale_in    = 1'b1;
               end else if (stale_ff) begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_SCAN: begin
            if (!scan_stat.busy) begin
               stale_in = cfg_write;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            res_in.distance = scan_stat.any_white ? rd_data_a[DIST_W-1:0] : '0;
            res_in.no_white = !scan_stat.any_white;
            res_in.outside  = 1'b0;
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/dtx_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module dtx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hw/rtl/dtx_mem.sv =====
// ----------------------------------------------------------------------------
// Pixel and distance store
// Holds the image bit and distance of every pixel in one RAM and forwards
// a write to a read of the same entry issued in the same cycle.
// ----------------------------------------------------------------------------
module dtx_mem
   import dtx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mem_wr_type         wr,
   input  mem_rd_type         rd,
   output logic [ENTRY_W-1:0] rd_data_a,
   output logic [ENTRY_W-1:0] rd_data_b
);

   logic [ENTRY_W-1:0] ram_a;
   logic [ENTRY_W-1:0] ram_b;
   logic               fwd_a_ff;
   logic               fwd_a_in;
   logic               fwd_b_ff;
   logic               fwd_b_in;
   logic [ENTRY_W-1:0] fwd_data_ff;

   dtx_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MEM_DEPTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr.en),
      .wr_addr  (wr.addr),
      .wr_data  (wr.data),
      .rd_addr_a(rd.addr_a),
      .rd_addr_b(rd.addr_b),
      .rd_data_a(ram_a),
      .rd_data_b(ram_b)
   );

   assign fwd_a_in = wr.en && (wr.addr == rd.addr_a);
   assign fwd_b_in = wr.en && (wr.addr == rd.addr_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_a_ff <= 1'b0;
         fwd_b_ff <= 1'b0;
      end else begin
         fwd_a_ff <= fwd_a_in;
         fwd_b_ff <= fwd_b_in;
      end
      fwd_data_ff <= wr.data;
   end

   assign rd_data_a = fwd_a_ff ? fwd_data_ff : ram_a;
   assign rd_data_b = fwd_b_ff ? fwd_data_ff : ram_b;

endmodule

// ===== hw/rtl/dtx_csr.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Window size registers behind the APB-style port, clamped to the store size.
// ----------------------------------------------------------------------------
module dtx_csr
   import dtx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output logic [REG_W-1:0]   eff_rows,
   output logic [REG_W-1:0]   eff_cols,
   output logic               cfg_write
);

   logic [REG_W-1:0] num_rows_ff;
   logic [REG_W-1:0] num_rows_in;
   logic [REG_W-1:0] num_cols_ff;
   logic [REG_W-1:0] num_cols_in;
   reg_idx_type      idx;

   assign pready    = 1'b1;
   assign idx       = reg_idx_type'(paddr[2]);
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (cfg_write) begin
         unique case (idx)
            REG_NUM_ROWS: num_rows_in = pwdata[REG_W-1:0];
            REG_NUM_COLS: num_cols_in = pwdata[REG_W-1:0];
            default:      num_rows_in = num_rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= REG_W'(MAX_ROWS);
         num_cols_ff <= REG_W'(MAX_COLS);
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_NUM_ROWS: prdata = PDATA_W'(num_rows_ff);
         REG_NUM_COLS: prdata = PDATA_W'(num_cols_ff);
         default:      prdata = '0;
      endcase
   end

   assign eff_rows = (num_rows_ff > REG_W'(MAX_ROWS)) ? REG_W'(MAX_ROWS) : num_rows_ff;
   assign eff_cols = (num_cols_ff > REG_W'(MAX_COLS)) ? REG_W'(MAX_COLS) : num_cols_ff;

endmodule

// ===== hw/rtl/dtx_scan.sv =====
// ----------------------------------------------------------------------------
// Raster scan engine
// Forward and backward raster passes over the store, one pixel per cycle,
// with a read stage and a compute and write-back stage.
// ----------------------------------------------------------------------------
module dtx_scan
   import dtx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [REG_W-1:0]   eff_rows,
   input  logic [REG_W-1:0]   eff_cols,
   input  logic [ENTRY_W-1:0] rd_data_a,
   input  logic [ENTRY_W-1:0] rd_data_b,
   output mem_rd_type         scan_rd,
   output mem_wr_type         scan_wr,
   output scan_stat_type      stat
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FWD,
      PH_BWD
   } phase_type;

   phase_type         phase_ff;
   phase_type         phase_in;
   logic [ROW_W-1:0]  r_ff;
   logic [ROW_W-1:0]  r_in;
   logic [COL_W-1:0]  c_ff;
   logic [COL_W-1:0]  c_in;
   logic              s2_valid_ff;
   logic              s2_bwd_ff;
   logic [ROW_W-1:0]  s2_r_ff;
   logic [COL_W-1:0]  s2_c_ff;
   logic [DIST_W-1:0] prev_d_ff;
   logic [DIST_W-1:0] prev_d_in;
   logic              any_white_ff;
   logic              any_white_in;

   logic [ROW_W-1:0]  last_r;
   logic [COL_W-1:0]  last_c;
   logic [DIST_W-1:0] d_fwd;
   logic [DIST_W-1:0] d_bwd;
   logic [DIST_W-1:0] d_new;
   logic [DIST_W-1:0] up_d;
   logic [DIST_W-1:0] left_d;
   logic [DIST_W-1:0] down_d;
   logic [DIST_W-1:0] right_d;

   assign last_r = ROW_W'(eff_rows - REG_W'(1));
   assign last_c = COL_W'(eff_cols - REG_W'(1));

   always_comb begin
      phase_in = phase_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      scan_rd.addr_a = {r_ff, c_ff};
      scan_rd.addr_b = {r_ff - ROW_W'(1), c_ff};
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_FWD;
               r_in     = '0;
               c_in     = '0;
            end
         end
         PH_FWD: begin
            if (c_ff == last_c) begin
               if (r_ff == last_r) begin
                  phase_in = PH_BWD;
                  r_in     = last_r;
                  c_in     = last_c;
               end else begin
                  r_in = r_ff + ROW_W'(1);
                  c_in = '0;
               end
            end else begin
               c_in = c_ff + COL_W'(1);
            end
         end
         PH_BWD: begin
            scan_rd.addr_b = {r_ff + ROW_W'(1), c_ff};
            if (c_ff == '0) begin
               if (r_ff == '0) begin
                  phase_in = PH_IDLE;
               end else begin
                  r_in = r_ff - ROW_W'(1);
                  c_in = last_c;
               end
            end else begin
               c_in = c_ff - COL_W'(1);
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      up_d    = (s2_r_ff != '0) ? dist_inc(rd_data_b[DIST_W-1:0]) : DIST_INF;
      left_d  = (s2_c_ff != '0) ? dist_inc(prev_d_ff) : DIST_INF;
      down_d  = (({1'b0, s2_r_ff} + REG_W'(1)) < eff_rows) ?
                dist_inc(rd_data_b[DIST_W-1:0]) : DIST_INF;
      right_d = (({1'b0, s2_c_ff} + REG_W'(1)) < eff_cols) ?
                dist_inc(prev_d_ff) : DIST_INF;
      d_fwd   = rd_data_a[DIST_W] ? '0 : dist_min(up_d, left_d);
      d_bwd   = dist_min(rd_data_a[DIST_W-1:0], dist_min(down_d, right_d));
      d_new   = s2_bwd_ff ? d_bwd : d_fwd;
   end

   always_comb begin
      scan_wr.en   = s2_valid_ff;
      scan_wr.addr = {s2_r_ff, s2_c_ff};
      scan_wr.data = {rd_data_a[DIST_W], d_new};
      prev_d_in    = s2_valid_ff ? d_new : prev_d_ff;
      any_white_in = any_white_ff;
      if (start) begin
         any_white_in = 1'b0;
      end else if (s2_valid_ff && !s2_bwd_ff && rd_data_a[DIST_W]) begin
         any_white_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         s2_valid_ff  <= 1'b0;
         any_white_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         s2_valid_ff  <= (phase_ff != PH_IDLE);
         any_white_ff <= any_white_in;
      end
      r_ff      <= r_in;
      c_ff      <= c_in;
      s2_bwd_ff <= (phase_ff == PH_BWD);
      s2_r_ff   <= r_ff;
      s2_c_ff   <= c_ff;
      prev_d_ff <= prev_d_in;
   end

   assign stat.busy      = (phase_ff != PH_IDLE);
   assign stat.any_white = any_white_ff;

endmodule

// ===== hw/rtl/dtx_checker.sv =====
// ----------------------------------------------------------------------------
// Distance transform port checker
// Watches the ports of the core for reset and result consistency.
// ----------------------------------------------------------------------------
module dtx_checker
   import dtx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input dtx_rsp_type rsp_data
);

   a_clear_blocks_input: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input beat offered as ready right after reset");

   a_reset_drops_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed or dropped");

   a_outside_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outside |->
         rsp_data.distance == '0 && !rsp_data.no_white)
      else $error("outside result carries a distance or no_white");

   a_no_white_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_white |-> rsp_data.distance == '0 && !req_valid ||
         rsp_valid && rsp_data.no_white && rsp_data.distance == '0)
      else $error("no_white result carries a distance");

endmodule

bind binary_image_distance_transform_core dtx_checker u_checker (.*);
